@@ rtl/core/qdc_pkg.sv @@
package qdc_pkg;

   // command codes of the request opcode field
   typedef enum logic [2:0] {
      OP_SAMPLE      = 3'd0,
      OP_READ        = 3'd1,
      OP_RESET       = 3'd2,
      OP_CENTER      = 3'd3,
      OP_GET_MIN     = 3'd4,
      OP_GET_MAX     = 3'd5,
      OP_SET_ADDRESS = 3'd6,
      OP_GET_ADDRESS = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      STEP_NONE = 2'd0,
      STEP_UP   = 2'd1,
      STEP_DOWN = 2'd2
   } step_type;

   localparam int ADDRESS_BITS = 7;
   localparam logic [ADDRESS_BITS-1:0] DEFAULT_ADDRESS = 7'h39;
   localparam logic [ADDRESS_BITS-1:0] ADDRESS_LIMIT   = 7'd127;

   localparam int REPLY_BITS     = 32;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   typedef struct packed {
      opcode_type  opcode;
      logic [1:0]  pins;
      logic [7:0]  new_address;
   } req_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
   } rsp_type;

   // one queued reply: a word sent low byte first, or a single byte
   typedef struct packed {
      logic [REPLY_BITS-1:0] word;
      logic                  single;
   } entry_type;

   // 4x decode table, index is {previous b, previous a, b, a}
   function automatic step_type decode_step(input logic [3:0] idx);
      step_type s;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: s = STEP_UP;
         4'd2, 4'd4, 4'd11, 4'd13: s = STEP_DOWN;
         default: s = STEP_NONE;
      endcase
      return s;
   endfunction

endpackage

@@ rtl/core/qdc_front.sv @@
module qdc_front #(
   parameter int COUNTER_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  qdc_pkg::req_type             req_payload,
   input  logic                         csr_write_enable,
   input  logic [qdc_pkg::ADDRESS_BITS-1:0] csr_write_data,
   input  logic                         queue_full,
   output logic                         push_valid,
   output qdc_pkg::entry_type           push_entry
);
   import qdc_pkg::*;

   localparam logic signed [COUNTER_BITS-1:0] POS_MIN =
      {1'b1, {(COUNTER_BITS-1){1'b0}}};
   localparam logic signed [COUNTER_BITS-1:0] POS_MAX =
      {1'b0, {(COUNTER_BITS-1){1'b1}}};

   logic signed [COUNTER_BITS-1:0] pos_ff, pos_in;
   logic [1:0]                     prev_pins_ff, prev_pins_in;
   logic [ADDRESS_BITS-1:0]        dev_addr_ff, dev_addr_in;
   logic                           accept;
   logic [ADDRESS_BITS-1:0]        addr_out;
   step_type                       step;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign step      = decode_step({prev_pins_ff, req_payload.pins});
   assign addr_out  = (dev_addr_ff == ADDRESS_LIMIT) ? DEFAULT_ADDRESS : dev_addr_ff;

   always_comb begin
      pos_in       = pos_ff;
      prev_pins_in = prev_pins_ff;
      dev_addr_in  = csr_write_enable ? csr_write_data : dev_addr_ff;
      push_valid   = 1'b0;
      push_entry   = '{word: REPLY_BITS'(pos_ff), single: 1'b0};
      if (accept) begin
         case (req_payload.opcode)
            OP_SAMPLE: begin
               prev_pins_in = req_payload.pins;
               case (step)
                  STEP_UP:   pos_in = pos_ff + COUNTER_BITS'(1);
                  STEP_DOWN: pos_in = pos_ff - COUNTER_BITS'(1);
                  default:   pos_in = pos_ff;
               endcase
            end
            OP_READ: begin
               push_valid = 1'b1;
            end
            OP_RESET, OP_CENTER: begin
               pos_in = '0;
            end
            OP_GET_MIN: begin
               push_valid      = 1'b1;
               push_entry.word = REPLY_BITS'(POS_MIN);
            end
            OP_GET_MAX: begin
               push_valid      = 1'b1;
               push_entry.word = REPLY_BITS'(POS_MAX);
            end
            OP_GET_ADDRESS: begin
               push_valid = 1'b1;
               push_entry = '{word: REPLY_BITS'(addr_out), single: 1'b1};
            end
            default: begin
               // set address: stored nowhere visible
               pos_in = pos_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         prev_pins_ff <= '0;
         dev_addr_ff  <= DEFAULT_ADDRESS;
      end else begin
         pos_ff       <= pos_in;
         prev_pins_ff <= prev_pins_in;
         dev_addr_ff  <= dev_addr_in;
      end
   end

endmodule

@@ rtl/core/qdc_queue.sv @@
module qdc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  qdc_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output qdc_pkg::entry_type head
);
   import qdc_pkg::*;

   entry_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign full    = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_BITS+1)'(do_push)
                           - (QUEUE_PTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/qdc_back.sv @@
module qdc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  qdc_pkg::entry_type queue_head,
   output logic               queue_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output qdc_pkg::rsp_type   rsp_payload
);
   import qdc_pkg::*;

   logic                  busy_ff, busy_in;
   logic [REPLY_BITS-1:0] word_ff, word_in;
   logic [1:0]            left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_payload_ff, rsp_payload_in;
   logic                  out_free;
   logic                  have_byte;
   logic [REPLY_BITS-1:0] src_word;
   logic [1:0]            src_left;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign have_byte = busy_ff || !queue_empty;
   assign src_word  = busy_ff ? word_ff : queue_head.word;
   assign src_left  = busy_ff ? left_ff : (queue_head.single ? 2'd0 : 2'd3);
   assign queue_pop = out_free && !busy_ff && !queue_empty;

   always_comb begin
      busy_in        = busy_ff;
      word_in        = word_ff;
      left_in        = left_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (out_free) begin
         rsp_valid_in = have_byte;
         if (have_byte) begin
            rsp_payload_in = '{data_byte: src_word[7:0], last_byte: (src_left == 2'd0)};
            busy_in        = (src_left != 2'd0);
            word_in        = src_word >> 8;
            left_in        = src_left - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff        <= word_in;
      left_ff        <= left_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ rtl/core/quadrature_decoder_counter.sv @@
// 4x quadrature decoder with a wrapping signed position counter of COUNTER_BITS
// bits behind a byte command port. A pin sample transaction (bits b,a) steps the
// position by -1, 0 or +1 from the previous and current levels and is taken every
// clock unless requests stall, as are reset, center and set address, which give
// no reply. Read, get min and get max reply with four bytes (value sign-extended
// to 32 bits, low byte first, last_byte on the fourth); get address replies with
// one byte, and a device address of 127 reads back as 57. The front end answers
// a command in the cycle it is accepted, so a read returns the position as of
// that transaction; a four-deep reply queue feeds a byte serializer that sends
// one byte per clock while rsp_stall is low, and requests stall only while the
// queue holds four pending replies.
module quadrature_decoder_counter #(
   parameter int COUNTER_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  qdc_pkg::req_type                  req_payload,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output qdc_pkg::rsp_type                  rsp_payload,
   // device address register
   input  logic                              csr_write_enable,
   input  logic [qdc_pkg::ADDRESS_BITS-1:0]  csr_write_data
);
   import qdc_pkg::*;

   // front end to reply queue
   logic      push_valid;
   entry_type push_entry;
   logic      queue_full;
   // reply queue to serializer
   logic      queue_pop;
   logic      queue_empty;
   entry_type queue_head;

   // decode, position counter and command classification
   qdc_front #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   // pending replies between the two halves
   qdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .empty      (queue_empty),
      .head       (queue_head)
   );

   // byte serializer with registered response output
   qdc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
